/* sv/ssk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_pkg: shared types and codes for the searchable stack engine
// Opcodes, status codes, scan record and broadcast control bundle.
// ----------------------------------------------------------------------------
package ssk_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;
  // Index and count widths cover the largest supported depth (1024)
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Running scan result handed from cell to cell
  typedef struct packed {
    logic                     any;
    logic signed [DATA_W-1:0] mn;
    logic signed [DATA_W-1:0] mx;
    logic                     kf;
    logic [IDX_W-1:0]         kidx;
    logic                     sf;
    logic signed [DATA_W-1:0] sval;
    logic [IDX_W-1:0]         sidx;
    logic signed [DATA_W-1:0] top;
  } rec_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic [CNT_W-1:0]         cnt;
    logic                     tsel;
    logic [IDX_W-1:0]         tidx;
    logic                     we;
    logic [IDX_W-1:0]         widx;
  } ctl_t;

endpackage

/* sv/searchable_stack_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_stack_engine: bounded stack with associative search
// Push, pop or query; reports min, max, key match, successor and reach cost.
// ----------------------------------------------------------------------------
//  channel  handshake             fields
//  in       in_valid / in_ready   opcode, value, position
//  out      out_valid / out_ready status .. reach_cost
//
//  From accept to result, the scan word walks the cell chain one cell per
//  cycle, after a pushed entry has landed in its cell. One word is in the
//  chain at a time; the next word is taken the cycle after a result is
//  loaded, even while that result still waits in the output register. A
//  held result stalls the end of the scan.
//  Reset clears the count and handshake state; entries hold no reset.
// ----------------------------------------------------------------------------
module searchable_stack_engine import ssk_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic signed [DATA_W-1:0] value,
  input  logic [6:0]               position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] top_value,
  output logic [6:0]               entry_count,
  output logic signed [DATA_W-1:0] min_value,
  output logic signed [DATA_W-1:0] max_value,
  output logic signed [6:0]        key_index,
  output logic signed [6:0]        successor_index,
  output logic signed [7:0]        reach_cost
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
  // last scan step: the chain length plus the entry write
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(DEPTH + 1);
  localparam int DW = CNT_W + 2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  scnt;
  logic [CNT_W-1:0]  cnt;
  ctl_t              ctl;
  logic [1:0]        st_q;
  logic signed [7:0] cost_q;
  rec_t              rec [DEPTH+1];

  logic              acc, fin;
  logic              push_ok;
  logic [CNT_W-1:0]  cnt_next;
  logic [1:0]        st_next;
  logic              tsel_next;
  logic [CNT_W-1:0]  tidx_next;
  logic signed [DW-1:0] d, pos_s;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign fin      = (state == S_SCAN) && (scnt == SCAN_END) && (!out_valid || out_ready);

  // Operation decode and new count
  always_comb begin
    push_ok   = 1'b0;
    cnt_next  = cnt;
    st_next   = ST_OK;
    tsel_next = 1'b0;
    tidx_next = cnt - CNT_W'(1);
    case (opcode)
      OP_PUSH: begin
        if (cnt >= FULL) begin
          st_next = ST_FULL;
        end else begin
          push_ok  = 1'b1;
          cnt_next = cnt + CNT_W'(1);
        end
        tsel_next = 1'b1;
        tidx_next = cnt_next - CNT_W'(1);
      end
      OP_POP: begin
        if (cnt == '0) begin
          st_next = ST_EMPTY;
        end else begin
          cnt_next  = cnt - CNT_W'(1);
          tsel_next = 1'b1;
          tidx_next = cnt - CNT_W'(1);
        end
      end
      default: begin
        if (cnt == '0) st_next = ST_EMPTY;
        else tsel_next = 1'b1;
      end
    endcase
  end

  // Reach cost on the new count
  assign pos_s = $signed(DW'(position));
  assign d     = $signed(DW'(cnt_next)) - pos_s;

  // Control and broadcast registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      scnt   <= '0;
      ctl.we <= 1'b0;
    end else begin
      ctl.we <= 1'b0;
      if (acc) begin
        state    <= S_SCAN;
        scnt     <= '0;
        cnt      <= cnt_next;
        ctl.we   <= push_ok;
        ctl.key  <= value;
        ctl.cnt  <= cnt_next;
        ctl.tsel <= tsel_next;
        ctl.tidx <= IDX_W'(tidx_next);
        ctl.widx <= IDX_W'(cnt);
      end else if (state == S_SCAN) begin
        if (scnt != SCAN_END) scnt <= scnt + CNT_W'(1);
        if (fin) state <= S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      st_q     <= st_next;
      cost_q   <= (d <= pos_s) ? 8'(d) : 8'(-pos_s);
    end
  end

  // Cell chain
  assign rec[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ssk_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .rec_in  (rec[i]),
      .rec_out (rec[i+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status          <= st_q;
      top_value       <= rec[DEPTH].top;
      entry_count     <= 7'(ctl.cnt);
      min_value       <= rec[DEPTH].mn;
      max_value       <= rec[DEPTH].mx;
      key_index       <= rec[DEPTH].kf ? 7'(rec[DEPTH].kidx) : '1;
      successor_index <= rec[DEPTH].sf ? 7'(rec[DEPTH].sidx) : '1;
      reach_cost      <= cost_q;
    end
  end

endmodule

/* sv/ssk_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_cell: one stack entry with its slice of the search chain
// Holds one entry, folds it into the passing scan word, registers the result.
// ----------------------------------------------------------------------------
module ssk_cell import ssk_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  ctl_t ctl,
  input  rec_t rec_in,
  output rec_t rec_out
);

  localparam logic [IDX_W-1:0] MY = IDX_W'(IDX);

  logic signed [DATA_W-1:0] entry;
  logic                     filled;
  rec_t                     rec_next;

  // Entry storage
  always_ff @(posedge clk) begin
    if (ctl.we && ctl.widx == MY) begin
      entry <= ctl.key;
    end
  end

  assign filled = CNT_W'(IDX) < ctl.cnt;

  // Fold this entry into the running result
  always_comb begin
    rec_next = rec_in;
    if (filled) begin
      if (!rec_in.any || entry < rec_in.mn) rec_next.mn = entry;
      if (!rec_in.any || entry > rec_in.mx) rec_next.mx = entry;
      rec_next.any = 1'b1;
      if (!rec_in.kf && entry == ctl.key) begin
        rec_next.kf   = 1'b1;
        rec_next.kidx = MY;
      end
      // ascending scan with <= keeps the highest index among ties
      if (entry > ctl.key && (!rec_in.sf || entry <= rec_in.sval)) begin
        rec_next.sf   = 1'b1;
        rec_next.sval = entry;
        rec_next.sidx = MY;
      end
    end
    if (ctl.tsel && ctl.tidx == MY) rec_next.top = entry;
  end

  always_ff @(posedge clk) begin
    rec_out <= rec_next;
  end

endmodule

/* sv/ssk_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_checker: port-level checks for the searchable stack engine
// Watches the handshakes and result consistency; bound to the top level.
// ----------------------------------------------------------------------------
module ssk_checker import ssk_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               status,
  input logic signed [DATA_W-1:0] top_value,
  input logic signed [DATA_W-1:0] min_value,
  input logic signed [DATA_W-1:0] max_value,
  input logic signed [6:0]        key_index,
  input logic signed [6:0]        successor_index
);

  // a result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(top_value))
    else $error("result word dropped while stalled");

  // one word in the chain at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken during scan");

  // empty result carries neutral fields
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> top_value == 0 && min_value == 0 &&
    max_value == 0 && key_index == -7'sd1 && successor_index == -7'sd1)
    else $error("empty result carries data");

  // minimum never exceeds maximum
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_value <= max_value)
    else $error("min above max");

endmodule

bind searchable_stack_engine ssk_checker u_ssk_checker (.*);
